// File: hdl/bgkc_pkg.sv
// Shared types, constants and helper functions of the D2Q9 BGK collision pipeline.
package bgkc_pkg;

	// Field and port widths.
	localparam int DATA_W    = 32;
	localparam int DIR_W     = 4;
	localparam int OMEGA_W   = 31;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int IN_DATA_W = 6 * DATA_W;

	// Number of register stages from input to output.
	localparam int NSTG = 12;

	// Configuration register indexes (paddr[2]).
	localparam logic REG_RELAX_RATE = 1'b0;
	localparam logic [OMEGA_W-1:0] RELAX_RATE_RESET = 31'h4000_0000;

	// Direction codes.
	localparam logic [DIR_W-1:0] DIR_REST = 4'd0;
	localparam logic [DIR_W-1:0] DIR_PX   = 4'd1;
	localparam logic [DIR_W-1:0] DIR_PY   = 4'd2;
	localparam logic [DIR_W-1:0] DIR_NX   = 4'd3;
	localparam logic [DIR_W-1:0] DIR_NY   = 4'd4;
	localparam logic [DIR_W-1:0] DIR_PXPY = 4'd5;
	localparam logic [DIR_W-1:0] DIR_NXPY = 4'd6;
	localparam logic [DIR_W-1:0] DIR_NXNY = 4'd7;
	localparam logic [DIR_W-1:0] DIR_PXNY = 4'd8;

	// Lattice velocity components.
	localparam logic signed [1:0] C_ZERO = 2'sb00;
	localparam logic signed [1:0] C_POS  = 2'sb01;
	localparam logic signed [1:0] C_NEG  = 2'sb11;

	// Weight class: rest 4/9, axis 1/9, diagonal 1/36.
	typedef enum logic [1:0] {
		KSEL_REST,
		KSEL_AXIS,
		KSEL_DIAG
	} ksel_t;

	typedef struct packed {
		logic             bad;
		ksel_t            ksel;
		logic signed [1:0] cx;
		logic signed [1:0] cy;
	} dir_info_t;

	// Divide-by-3 constants: z = zh*2^18 + zl, floor(z/3) = zh*C3_HI + floor((zh+zl)/3).
	localparam logic [16:0] C3_HI    = 17'd87381;
	localparam logic [20:0] C3_RECIP = 21'd1398102;
	// Divide-by-9 constants: z = zh*2^24 + zl, floor(z/9) = zh*C9_HI + floor((zh+zl)/9).
	localparam logic [20:0] C9_HI    = 21'd1864135;
	localparam logic [26:0] C9_RECIP = 27'd119304648;

	// Offsets that keep the dividends non-negative (multiples of the divisor).
	localparam logic signed [35:0] OFF3     = 36'sd12884901888;
	localparam logic signed [35:0] OFF3_Q   = 36'sd4294967296;
	localparam logic signed [45:0] OFF9     = 46'sd9895604649984;
	localparam logic signed [45:0] OFF9_Q   = 46'sd1099511627776;
	// Two in Q.28, the constant term of twice the equilibrium polynomial.
	localparam logic signed [43:0] TWO_FIX  = 44'sd536870912;

	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	// Direction code to lattice vector and weight class.
	function automatic dir_info_t dir_decode(input logic [DIR_W-1:0] dir);
		dir_info_t r;
		r.bad  = 1'b0;
		r.ksel = KSEL_AXIS;
		r.cx   = C_ZERO;
		r.cy   = C_ZERO;
		unique case (dir)
			DIR_REST: r.ksel = KSEL_REST;
			DIR_PX:   r.cx = C_POS;
			DIR_PY:   r.cy = C_POS;
			DIR_NX:   r.cx = C_NEG;
			DIR_NY:   r.cy = C_NEG;
			DIR_PXPY: begin
				r.ksel = KSEL_DIAG;
				r.cx   = C_POS;
				r.cy   = C_POS;
			end
			DIR_NXPY: begin
				r.ksel = KSEL_DIAG;
				r.cx   = C_NEG;
				r.cy   = C_POS;
			end
			DIR_NXNY: begin
				r.ksel = KSEL_DIAG;
				r.cx   = C_NEG;
				r.cy   = C_NEG;
			end
			DIR_PXNY: begin
				r.ksel = KSEL_DIAG;
				r.cx   = C_POS;
				r.cy   = C_NEG;
			end
			default: begin
				r.bad  = 1'b1;
				r.ksel = KSEL_REST;
			end
		endcase
		return r;
	endfunction

	// One term of a dot product with a lattice vector component of -1, 0 or +1.
	function automatic logic signed [33:0] axis_term(input logic signed [1:0] c,
		input logic signed [DATA_W-1:0] v);
		logic signed [33:0] r;
		case (c)
			C_POS:   r = 34'(v);
			C_NEG:   r = -34'(v);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Clamp to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > SAT_HI) begin
			r = 32'sh7fff_ffff;
		end else if (x < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/bgkc_apb_regs.sv
// APB configuration register block holding the relaxation rate.
module bgkc_apb_regs
	import bgkc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	output logic [OMEGA_W-1:0]  relaxation_rate
);

	logic               reg_idx;
	logic               wr_en;
	logic [OMEGA_W-1:0] omega_q;

	// The register index sits above the byte offset.
	assign reg_idx = paddr[PADDR_W-1];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_q <= RELAX_RATE_RESET;
		end else if (wr_en && (reg_idx == REG_RELAX_RATE)) begin
			omega_q <= pwdata[OMEGA_W-1:0];
		end
	end

	// Read decode; addresses past the register list read as zero.
	always_comb begin
		unique case (reg_idx)
			REG_RELAX_RATE: prdata = {{(PDATA_W-OMEGA_W){1'b0}}, omega_q};
			default:        prdata = '0;
		endcase
	end

	assign relaxation_rate = omega_q;

endmodule

// File: hdl/bgk_collision_d2q9_top.sv
// Throughput: one request per cycle; every stage holds one request and moves on
// when the stage after it is empty or moving, so bubbles close up under a stall.
// Reset: arst_n clears all stage valid bits and restores the relaxation rate to 1.0;
// the data registers are not reset.
module bgk_collision_d2q9_top
	import bgkc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Slave side.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// dist_in[31:0], node_density[63:32], velocity_x[95:64], velocity_y[127:96],
	// force_x[159:128], force_y[191:160]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// direction[3:0]
	input  logic [DIR_W-1:0]      s_tuser,
	// Master side.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// dist_out[31:0]
	output logic [DATA_W-1:0]     m_tdata,
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	logic [OMEGA_W-1:0] omega;

	bgkc_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.relaxation_rate (omega)
	);

	// ------------------------------------------------------------------
	// Pipeline control
	// ------------------------------------------------------------------
	logic [NSTG:1]   stg_vld_q;
	logic [NSTG+1:1] stg_en;

	// A stage may load when it is empty or its content moves on.
	always_comb begin
		stg_en[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			stg_en[k] = !stg_vld_q[k] || stg_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (stg_en[1]) begin
				stg_vld_q[1] <= s_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stg_en[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	assign s_tready = stg_en[1];
	assign m_tvalid = stg_vld_q[NSTG];

	// ------------------------------------------------------------------
	// Stage 1: decode direction, form c.u and c.g
	// ------------------------------------------------------------------
	dir_info_t                info_c;
	logic signed [DATA_W-1:0] f_in, rho_in, ux_in, uy_in, gx_in, gy_in;

	assign info_c = dir_decode(s_tuser);
	assign f_in   = s_tdata[1*DATA_W-1:0*DATA_W];
	assign rho_in = s_tdata[2*DATA_W-1:1*DATA_W];
	assign ux_in  = s_tdata[3*DATA_W-1:2*DATA_W];
	assign uy_in  = s_tdata[4*DATA_W-1:3*DATA_W];
	assign gx_in  = s_tdata[5*DATA_W-1:4*DATA_W];
	assign gy_in  = s_tdata[6*DATA_W-1:5*DATA_W];

	dir_info_t                info_s1;
	logic signed [33:0]       cu_s1, cg_s1;
	logic signed [DATA_W-1:0] ux_s1, uy_s1, f_s1, rho_s1;

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			info_s1 <= info_c;
			cu_s1   <= axis_term(info_c.cx, ux_in) + axis_term(info_c.cy, uy_in);
			cg_s1   <= axis_term(info_c.cx, gx_in) + axis_term(info_c.cy, gy_in);
			ux_s1   <= ux_in;
			uy_s1   <= uy_in;
			f_s1    <= f_in;
			rho_s1  <= rho_in;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squares of c.u and of the velocity; offset force dividend
	// ------------------------------------------------------------------
	logic signed [67:0] cu_ext, cu_sq;
	logic signed [63:0] ux_ext, uy_ext, ux_sq, uy_sq;
	logic signed [33:0] gdiv_c;
	logic signed [35:0] z3_c;

	assign cu_ext = 68'(cu_s1);
	assign cu_sq  = cu_ext * cu_ext;
	assign ux_ext = 64'(ux_s1);
	assign uy_ext = 64'(uy_s1);
	assign ux_sq  = ux_ext * ux_ext;
	assign uy_sq  = uy_ext * uy_ext;
	// Diagonal weight needs c.g/12, done as (c.g >> 2)/3.
	assign gdiv_c = (info_s1.ksel == KSEL_DIAG) ? (cg_s1 >>> 2) : cg_s1;
	assign z3_c   = 36'(gdiv_c) + OFF3;

	dir_info_t                info_s2;
	logic [36:0]              cusq_s2;
	logic [62:0]              uxsq_s2, uysq_s2;
	logic [34:0]              z3_s2;
	logic signed [33:0]       cu_s2;
	logic signed [DATA_W-1:0] f_s2, rho_s2;

	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			info_s2 <= info_s1;
			cusq_s2 <= cu_sq[64:28];
			uxsq_s2 <= ux_sq[62:0];
			uysq_s2 <= uy_sq[62:0];
			z3_s2   <= z3_c[34:0];
			cu_s2   <= cu_s1;
			f_s2    <= f_s1;
			rho_s2  <= rho_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: u^2 and the positive part of the polynomial
	// ------------------------------------------------------------------
	logic [63:0]        usq_sum;
	logic signed [43:0] t_c;

	assign usq_sum = {1'b0, uxsq_s2} + {1'b0, uysq_s2};
	assign t_c     = TWO_FIX + 44'(cu_s2) * 44'sd6 + $signed({7'b0, cusq_s2}) * 44'sd9;

	dir_info_t                info_s3;
	logic [35:0]              usq_s3;
	logic signed [43:0]       t_s3;
	logic [16:0]              zh3_s3;
	logic [18:0]              s3_s3;
	logic signed [DATA_W-1:0] f_s3, rho_s3;

	always_ff @(posedge clk) begin
		if (stg_en[3]) begin
			info_s3 <= info_s2;
			usq_s3  <= usq_sum[63:28];
			t_s3    <= t_c;
			zh3_s3  <= z3_s2[34:18];
			s3_s3   <= {2'b0, z3_s2[34:18]} + {1'b0, z3_s2[17:0]};
			f_s3    <= f_s2;
			rho_s3  <= rho_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: twice the polynomial, scaled by weight; force divide products
	// ------------------------------------------------------------------
	logic signed [43:0] p2_c, y_c;
	logic signed [45:0] z9_c;

	assign p2_c = t_s3 - $signed({8'b0, usq_s3}) * 44'sd3;

	// a = floor(P2*k/72): rest 2*P2/9, axis (P2/2)/9, diagonal (P2/8)/9.
	always_comb begin
		case (info_s3.ksel)
			KSEL_REST: y_c = p2_c <<< 1;
			KSEL_AXIS: y_c = p2_c >>> 1;
			KSEL_DIAG: y_c = p2_c >>> 3;
			default:   y_c = p2_c <<< 1;
		endcase
	end

	assign z9_c = 46'(y_c) + OFF9;

	dir_info_t                info_s4;
	logic [44:0]              z9_s4;
	logic [33:0]              fq1_s4;
	logic [39:0]              fq2_s4;
	logic signed [DATA_W-1:0] f_s4, rho_s4;

	always_ff @(posedge clk) begin
		if (stg_en[4]) begin
			info_s4 <= info_s3;
			z9_s4   <= z9_c[44:0];
			fq1_s4  <= {17'b0, zh3_s3} * {17'b0, C3_HI};
			fq2_s4  <= {21'b0, s3_s3} * {19'b0, C3_RECIP};
			f_s4    <= f_s3;
			rho_s4  <= rho_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: finish force term; fold the equilibrium dividend
	// ------------------------------------------------------------------
	logic signed [35:0] force_c;

	assign force_c = $signed({2'b0, fq1_s4}) + $signed({18'b0, fq2_s4[39:22]}) - OFF3_Q;

	dir_info_t                info_s5;
	logic [20:0]              zh9_s5;
	logic [24:0]              s9_s5;
	logic signed [33:0]       force_s5;
	logic signed [DATA_W-1:0] f_s5, rho_s5;

	always_ff @(posedge clk) begin
		if (stg_en[5]) begin
			info_s5  <= info_s4;
			zh9_s5   <= z9_s4[44:24];
			s9_s5    <= {4'b0, z9_s4[44:24]} + {1'b0, z9_s4[23:0]};
			force_s5 <= force_c[33:0];
			f_s5     <= f_s4;
			rho_s5   <= rho_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: divide-by-9 products
	// ------------------------------------------------------------------
	logic                     bad_s6;
	logic [41:0]              m1_s6;
	logic [51:0]              m2_s6;
	logic signed [33:0]       force_s6;
	logic signed [DATA_W-1:0] f_s6, rho_s6;

	always_ff @(posedge clk) begin
		if (stg_en[6]) begin
			bad_s6   <= info_s5.bad;
			m1_s6    <= {21'b0, zh9_s5} * {21'b0, C9_HI};
			m2_s6    <= {27'b0, s9_s5} * {25'b0, C9_RECIP};
			force_s6 <= force_s5;
			f_s6     <= f_s5;
			rho_s6   <= rho_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: weighted polynomial a = w*P in Q.28
	// ------------------------------------------------------------------
	logic signed [45:0] a_full;

	assign a_full = $signed({4'b0, m1_s6}) + $signed({24'b0, m2_s6[51:30]}) - OFF9_Q;

	logic                     bad_s7;
	logic signed [40:0]       a_s7;
	logic signed [33:0]       force_s7;
	logic signed [DATA_W-1:0] f_s7, rho_s7;

	always_ff @(posedge clk) begin
		if (stg_en[7]) begin
			bad_s7   <= bad_s6;
			a_s7     <= a_full[40:0];
			force_s7 <= force_s6;
			f_s7     <= f_s6;
			rho_s7   <= rho_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: rho * a as two partial products
	// ------------------------------------------------------------------
	logic signed [20:0] a_hi;
	logic signed [52:0] rho_ext;

	assign a_hi    = a_s7[40:20];
	assign rho_ext = 53'(rho_s7);

	logic                     bad_s8;
	logic signed [52:0]       ph_s8, pl_s8;
	logic signed [33:0]       force_s8;
	logic signed [DATA_W-1:0] f_s8;

	always_ff @(posedge clk) begin
		if (stg_en[8]) begin
			bad_s8   <= bad_s7;
			ph_s8    <= rho_ext * 53'(a_hi);
			pl_s8    <= rho_ext * $signed({33'b0, a_s7[19:0]});
			force_s8 <= force_s7;
			f_s8     <= f_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: combine partial products, floor shift and clamp feq
	// ------------------------------------------------------------------
	logic signed [73:0] rho_a;
	logic signed [45:0] feq_wide;

	assign rho_a    = (74'(ph_s8) <<< 20) + 74'(pl_s8);
	assign feq_wide = rho_a[73:28];

	logic                     bad_s9;
	logic signed [DATA_W-1:0] feq_s9;
	logic signed [33:0]       force_s9;
	logic signed [DATA_W-1:0] f_s9;

	always_ff @(posedge clk) begin
		if (stg_en[9]) begin
			bad_s9   <= bad_s8;
			feq_s9   <= sat32(64'(feq_wide));
			force_s9 <= force_s8;
			f_s9     <= f_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: non-equilibrium part f - feq
	// ------------------------------------------------------------------
	logic                     bad_s10;
	logic signed [32:0]       d_s10;
	logic signed [33:0]       force_s10;
	logic signed [DATA_W-1:0] f_s10;

	always_ff @(posedge clk) begin
		if (stg_en[10]) begin
			bad_s10   <= bad_s9;
			d_s10     <= 33'(f_s9) - 33'(feq_s9);
			force_s10 <= force_s9;
			f_s10     <= f_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: relaxation product (f - feq) * omega
	// ------------------------------------------------------------------
	logic                     bad_s11;
	logic signed [64:0]       prod_s11;
	logic signed [33:0]       force_s11;
	logic signed [DATA_W-1:0] f_s11;

	always_ff @(posedge clk) begin
		if (stg_en[11]) begin
			bad_s11   <= bad_s10;
			prod_s11  <= 65'(d_s10) * $signed({34'b0, omega});
			force_s11 <= force_s10;
			f_s11     <= f_s10;
		end
	end

	// ------------------------------------------------------------------
	// Stage 12: f - relax + force, clamped; unused codes pass f through
	// ------------------------------------------------------------------
	logic signed [34:0] relax_c;
	logic signed [37:0] res_c;

	assign relax_c = prod_s11[64:30];
	assign res_c   = 38'(f_s11) - 38'(relax_c) + 38'(force_s11);

	logic signed [DATA_W-1:0] dist_out_s12;

	always_ff @(posedge clk) begin
		if (stg_en[12]) begin
			dist_out_s12 <= bad_s11 ? f_s11 : sat32(64'(res_c));
		end
	end

	assign m_tdata = dist_out_s12;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// The slave side only stalls when every stage is occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&stg_vld_q))
		else $error("slave side stalled with an empty pipeline stage");

	// A held stage never drops its request.
	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((($past(stg_vld_q) & ~$past(stg_en[NSTG:1])) & ~stg_vld_q) == '0))
		else $error("a stalled pipeline stage lost its request");

	// The rest direction carries no force term.
	a_rest_force: assert property (@(posedge clk) disable iff (!arst_n)
		(stg_vld_q[5] && !info_s5.bad && (info_s5.ksel == KSEL_REST)) |-> (force_s5 == '0))
		else $error("nonzero force term on the rest direction");

	// The weighted polynomial fits its register after offset removal.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stg_vld_q[6] && !bad_s6) |-> (a_full[45:40] == {6{a_full[40]}}))
		else $error("weighted equilibrium polynomial out of range");

endmodule
